[rtl/chained_hash_table_top_defines.svh]
// Assertion macros shared by the hash table checker.
`ifndef CHAINED_HASH_TABLE_TOP_DEFINES_SVH
`define CHAINED_HASH_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define CHT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define CHT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/cht_pkg.sv]
// Shared constants, codes and controller/datapath interface types of the hash table.
package cht_pkg;

	localparam int BUCKETS   = 8;
	localparam int SLOTS     = 4;
	localparam int KEY_WIDTH = 32;

	localparam int BKT_W     = $clog2(BUCKETS);
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int FILL_W    = $clog2(SLOTS + 1);
	localparam int ADDR_W    = BKT_W + SLOT_W;
	localparam int DEPTH     = BUCKETS * SLOTS;
	localparam int CNT_W     = $clog2(KEY_WIDTH);
	localparam int CFG_W     = 4;
	localparam int OUT_TDATA_W = 8;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_FULL      = 2'd1,
		ST_DELETED   = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} op_t;

	// Commands from the controller
	typedef struct packed {
		logic    load;
		logic    div_step;
		logic    ins_wr;
		logic    scan_clr;
		logic    scan_rd;
		logic    idx_inc;
		logic    shift_rd;
		logic    move_wr;
		logic    fill_dec;
		logic    set_status;
		status_t status;
		logic    out_load;
	} cht_cmd_t;

	// Status back to the controller
	typedef struct packed {
		logic div_done;
		logic is_delete;
		logic full;
		logic scan_end;
		logic match;
		logic shift_end;
	} cht_sts_t;

endpackage

[rtl/chained_hash_table_top.sv]
// Top level of the chained hash table: stream ports, controller and datapath.
//
// Each key goes to bucket key mod bucket_count (count 0 reads as 1, above 8 as 8); an insert
// appends at the bucket tail (status full if its 4 slots are taken), a delete removes the first
// equal key and moves the later ones down. One item is handled at a time: the remainder is formed
// bit-serially, one key bit a cycle, and most of an item's time goes there; a delete then scans the
// bucket slot by slot and moves each later entry down. A finished result waits in an output
// register, and the next item is taken while it does. Fill counters are cleared at reset, with no
// clearing pass.
module chained_hash_table_top
	import cht_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// Bucket count register write
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_W-1:0]       cfg_data,       // bucket_count
	// Operation stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [KEY_WIDTH-1:0]   s_axis_tdata,   // [31:0] key
	input  logic                   s_axis_tuser,   // [0] func
	// Result stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [2:0] bucket, [7:3] zero
	output logic [1:0]             m_axis_tuser    // [1:0] status
);

	cht_cmd_t         cmd;
	cht_sts_t         sts;
	status_t          out_status;
	logic [BKT_W-1:0] out_bucket;

	assign cfg_ready = 1'b1;

	cht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	cht_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid),
		.cfg_value  (cfg_data),
		.in_func    (s_axis_tuser),
		.in_key     (s_axis_tdata),
		.cmd        (cmd),
		.sts        (sts),
		.out_status (out_status),
		.out_bucket (out_bucket)
	);

	assign m_axis_tdata = OUT_TDATA_W'(out_bucket);
	assign m_axis_tuser = out_status;

endmodule

[rtl/cht_datapath.sv]
// Hash table datapath: bit-serial modulo, fill counters, slot memory and result register.
module cht_datapath
	import cht_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_W-1:0]     cfg_value,
	input  logic                 in_func,
	input  logic [KEY_WIDTH-1:0] in_key,
	input  cht_cmd_t             cmd,
	output cht_sts_t             sts,
	output status_t              out_status,
	output logic [BKT_W-1:0]     out_bucket
);

	logic [CFG_W-1:0]     count_q;
	logic [CFG_W-1:0]     eff_count;
	logic [CFG_W-1:0]     divisor_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [KEY_WIDTH-1:0] div_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [BKT_W-1:0]     rem_q;
	logic [CFG_W-1:0]     rem_shift;
	logic [CFG_W-1:0]     rem_next;
	logic                 op_q;
	logic [FILL_W-1:0]    fill_q [BUCKETS];
	logic [FILL_W-1:0]    fill;
	logic [FILL_W-1:0]    idx_q;
	logic [FILL_W-1:0]    idx_inc;
	status_t              status_q;
	status_t              out_status_q;
	logic [BKT_W-1:0]     out_bucket_q;
	logic [KEY_WIDTH-1:0] mem [DEPTH];
	logic [KEY_WIDTH-1:0] rd_data_q;
	logic                 wr_en;
	logic [ADDR_W-1:0]    wr_addr;
	logic [KEY_WIDTH-1:0] wr_data;
	logic                 rd_en;
	logic [ADDR_W-1:0]    rd_addr;

	// Bucket count register, taken as 1..BUCKETS
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CFG_W'(7);
		end else if (cfg_we) begin
			count_q <= cfg_value;
		end
	end

	always_comb begin
		if (count_q == '0) begin
			eff_count = CFG_W'(1);
		end else if (count_q > CFG_W'(BUCKETS)) begin
			eff_count = CFG_W'(BUCKETS);
		end else begin
			eff_count = count_q;
		end
	end

	// Restoring remainder, one key bit per step, MSB first
	assign rem_shift = {rem_q, div_q[KEY_WIDTH-1]};
	assign rem_next  = (rem_shift >= divisor_q) ? (rem_shift - divisor_q) : rem_shift;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q     <= in_key;
			div_q     <= in_key;
			op_q      <= in_func;
			divisor_q <= eff_count;
			rem_q     <= '0;
			cnt_q     <= '0;
		end else if (cmd.div_step) begin
			div_q <= {div_q[KEY_WIDTH-2:0], 1'b0};
			rem_q <= rem_next[BKT_W-1:0];
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign fill    = fill_q[rem_q];
	assign idx_inc = idx_q + 1'b1;

	// Per-bucket fill counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < BUCKETS; b++) begin
				fill_q[b] <= '0;
			end
		end else if (cmd.ins_wr) begin
			fill_q[rem_q] <= fill + 1'b1;
		end else if (cmd.fill_dec) begin
			fill_q[rem_q] <= fill - 1'b1;
		end
	end

	// Slot index within the bucket
	always_ff @(posedge clk) begin
		if (cmd.scan_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_inc;
		end
	end

	// Slot memory ports
	assign wr_en   = cmd.ins_wr | cmd.move_wr;
	assign wr_addr = cmd.ins_wr ? {rem_q, fill[SLOT_W-1:0]} : {rem_q, idx_q[SLOT_W-1:0]};
	assign wr_data = cmd.ins_wr ? key_q : rd_data_q;
	assign rd_en   = cmd.scan_rd | cmd.shift_rd;
	assign rd_addr = cmd.shift_rd ? {rem_q, idx_inc[SLOT_W-1:0]} : {rem_q, idx_q[SLOT_W-1:0]};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Result status and output register
	always_ff @(posedge clk) begin
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
		if (cmd.out_load) begin
			out_status_q <= status_q;
			out_bucket_q <= rem_q;
		end
	end

	assign sts.div_done  = (cnt_q == CNT_W'(KEY_WIDTH - 1));
	assign sts.is_delete = (op_q == OP_DELETE);
	assign sts.full      = (fill == FILL_W'(SLOTS));
	assign sts.scan_end  = (idx_q == fill);
	assign sts.match     = (rd_data_q == key_q);
	assign sts.shift_end = (idx_inc == fill);

	assign out_status = out_status_q;
	assign out_bucket = out_bucket_q;

endmodule

[rtl/cht_ctrl.sv]
// Hash table controller: operation sequencer and output valid flag.
module cht_ctrl
	import cht_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  cht_sts_t sts,
	output cht_cmd_t cmd
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_DIV   = 8'b0000_0010,
		S_LOOK  = 8'b0000_0100,
		S_SCAN  = 8'b0000_1000,
		S_CMP   = 8'b0001_0000,
		S_SHIFT = 8'b0010_0000,
		S_MOVE  = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				if (sts.is_delete) begin
					cmd.scan_clr = 1'b1;
					state_d      = S_SCAN;
				end else if (sts.full) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_FULL;
					state_d        = S_DONE;
				end else begin
					cmd.ins_wr     = 1'b1;
					cmd.set_status = 1'b1;
					cmd.status     = ST_INSERTED;
					state_d        = S_DONE;
				end
			end
			S_SCAN: begin
				if (sts.scan_end) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_NOT_FOUND;
					state_d        = S_DONE;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = S_CMP;
				end
			end
			S_CMP: begin
				if (sts.match) begin
					state_d = S_SHIFT;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_SCAN;
				end
			end
			S_SHIFT: begin
				// Pull later entries down one slot until the tail
				if (sts.shift_end) begin
					cmd.fill_dec   = 1'b1;
					cmd.set_status = 1'b1;
					cmd.status     = ST_DELETED;
					state_d        = S_DONE;
				end else begin
					cmd.shift_rd = 1'b1;
					state_d      = S_MOVE;
				end
			end
			S_MOVE: begin
				cmd.move_wr = 1'b1;
				cmd.idx_inc = 1'b1;
				state_d     = S_SHIFT;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Output valid: set on load, cleared on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/cht_checker.sv]
// Port-level checker for the hash table, bound to the top level.
`include "chained_hash_table_top_defines.svh"

module cht_checker
	import cht_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   cfg_valid,
	input logic                   cfg_ready,
	input logic [CFG_W-1:0]       cfg_data,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic [KEY_WIDTH-1:0]   s_axis_tdata,
	input logic                   s_axis_tuser,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [1:0]             m_axis_tuser
);

	logic in_xfer;

	assign in_xfer = s_axis_tvalid && s_axis_tready;

	// A stalled result keeps its payload
	`CHT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

	// One item at a time: no second transfer right behind the first
	`CHT_ASSERT_NEXT(a_in_busy, in_xfer, !s_axis_tready, "input ready right after a transfer")

	// The bucket index fits three bits; the padding stays zero
	`CHT_ASSERT_SAME(a_pad_zero, m_axis_tvalid, m_axis_tdata[7:3] == 5'd0, "bucket padding not zero")

	// A result never rises too soon after an input transfer
	`CHT_ASSERT_SAME(a_min_latency, $rose(m_axis_tvalid), !$past(in_xfer) && !$past(in_xfer, 2), "result too early")

	// Unused here beyond the bind connection
	logic unused_ok;
	assign unused_ok = cfg_valid ^ cfg_ready ^ (^cfg_data) ^ (^s_axis_tdata) ^ s_axis_tuser;

endmodule

bind chained_hash_table_top cht_checker u_cht_checker (.*);

[tb/hash_table_checker.sv]
// Result checker for the chained hash table: tracks the table and compares every result.
`timescale 1ns / 1ps

module hash_table_checker
	import cht_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [KEY_WIDTH-1:0]   s_axis_tdata,
	input  logic                   s_axis_tuser,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic [1:0]             m_axis_tuser,
	output int unsigned            mismatch_count,
	output int unsigned            outstanding
);

	typedef struct packed {
		status_t    status;
		logic [2:0] bucket;
	} table_result_t;

	// Shadow copy of the table and of the bucket count register
	logic [CFG_W-1:0]     count_reg;
	logic [KEY_WIDTH-1:0] slot_key [BUCKETS][SLOTS];
	int unsigned          slot_fill [BUCKETS];
	table_result_t        expected_results [$];

	// Apply one operation to the shadow table and return the status and bucket it must report
	function automatic table_result_t apply_op(input op_t op, input logic [KEY_WIDTH-1:0] key);
		int unsigned   divisor;
		int unsigned   b;
		int unsigned   fill;
		int unsigned   i;
		table_result_t r;
		// zero reads as one bucket, anything above the table size as the table size
		divisor = (count_reg == 0) ? 1 : ((count_reg > BUCKETS) ? BUCKETS : count_reg);
		b = key % divisor;
		fill = slot_fill[b];
		r.bucket = b[2:0];
		if (op == OP_INSERT) begin
			if (fill >= SLOTS) begin
				r.status = ST_FULL;
			end else begin
				slot_key[b][fill] = key;
				slot_fill[b] = fill + 1;
				r.status = ST_INSERTED;
			end
		end else begin
			r.status = ST_NOT_FOUND;
			i = 0;
			while (i < fill && slot_key[b][i] != key)
				i++;
			// first match goes, later entries move down in order
			if (i < fill) begin
				for (; i + 1 < fill; i++)
					slot_key[b][i] = slot_key[b][i + 1];
				slot_fill[b] = fill - 1;
				r.status = ST_DELETED;
			end
		end
		return r;
	endfunction

	// Watch the three channels; results are matched before new items are queued
	always @(posedge clk or negedge arst_n) begin
		table_result_t want;
		if (!arst_n) begin
			count_reg = 4'd7;
			foreach (slot_fill[b])
				slot_fill[b] = 0;
			expected_results.delete();
			outstanding <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with no expectation: status %0d bucket %0d",
						m_axis_tuser, m_axis_tdata[2:0]);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (m_axis_tuser !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
						mismatch_count++;
					end
					if (m_axis_tdata[2:0] !== want.bucket) begin
						$error("bucket: expected %0d, actual %0d", want.bucket,
							m_axis_tdata[2:0]);
						mismatch_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				count_reg = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				expected_results.insert(expected_results.size(),
					apply_op(op_t'(s_axis_tuser), s_axis_tdata));
			outstanding <= expected_results.size();
		end
	end

endmodule

[tb/chained_hash_table_top_tb.sv]
// Testbench top for the chained hash table: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 1ps

module chained_hash_table_top_tb;
	import cht_pkg::*;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_W-1:0]       cfg_data;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [KEY_WIDTH-1:0]   s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [1:0]             m_axis_tuser;
	int unsigned            fail_count;
	int unsigned            pending;

	// sender pacing
	int unsigned            burst_left;
	bit                     sending;
	logic [KEY_WIDTH-1:0]   live_keys [$];

	chained_hash_table_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	hash_table_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tuser   (m_axis_tuser),
		.mismatch_count (fail_count),
		.outstanding    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard limit on run time
	initial begin
		#5_000_000;
		$display("chained_hash_table_top_tb: FAIL");
		$finish;
	end

	// Result side: the stall pattern changes from run to run among four modes
	initial begin
		int unsigned mode;
		int unsigned run;
		m_axis_tready <= 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			run = $urandom_range(20, 120);
			repeat (run) begin
				@(posedge clk);
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= ($urandom_range(0, 7) == 0);
					default: m_axis_tready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// One operation transfer, then a gap once the current burst runs out
	task automatic push_op(input op_t op, input logic [KEY_WIDTH-1:0] key);
		int unsigned gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= key;
		s_axis_tuser <= op;
		sending = 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			sending = 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 15);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(0, 9);
		end else begin
			burst_left--;
		end
	endtask

	// Stop sending and wait until every result has been taken
	task automatic wait_idle();
		if (sending) begin
			s_axis_tvalid <= 1'b0;
			sending = 1'b0;
		end
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Bucket count write, only with the table idle
	task automatic set_count(input logic [CFG_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random key: small values collide often, full-range ones toggle every bit
	function automatic logic [KEY_WIDTH-1:0] random_key();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 5)
			return $urandom_range(0, 63);
		else if (pick < 8)
			return $urandom;
		else
			return $urandom | 32'hFFFF_FF00;
	endfunction

	initial begin
		int unsigned          phase;
		int unsigned          n;
		int unsigned          idx;
		logic [CFG_W-1:0]     count;
		logic [KEY_WIDTH-1:0] k;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= OP_INSERT;
		sending = 1'b0;
		burst_left = 3;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset count of 7, fill bucket 0, overflow, shifts, duplicates
		push_op(OP_INSERT, 32'd0);
		push_op(OP_INSERT, 32'hFFFF_FFFF);
		push_op(OP_INSERT, 32'd7);
		push_op(OP_INSERT, 32'd14);
		push_op(OP_INSERT, 32'd21);
		push_op(OP_INSERT, 32'd28);
		push_op(OP_DELETE, 32'd99);
		push_op(OP_DELETE, 32'd14);
		push_op(OP_INSERT, 32'd7);
		push_op(OP_DELETE, 32'd7);
		push_op(OP_DELETE, 32'hFFFF_FFFF);
		push_op(OP_DELETE, 32'hFFFF_FFFF);
		// zero count acts as a single bucket; old keys stay put
		set_count(4'd0);
		push_op(OP_INSERT, 32'h8000_0000);
		push_op(OP_INSERT, 32'd5);
		push_op(OP_DELETE, 32'd21);
		// count above the table size clamps
		set_count(4'd15);
		push_op(OP_INSERT, 32'hFFFF_FFFF);
		push_op(OP_DELETE, 32'h8000_0000);
		push_op(OP_DELETE, 32'd3);
		set_count(4'd8);
		push_op(OP_INSERT, 32'hAAAA_AAAA);
		push_op(OP_INSERT, 32'h5555_5555);
		set_count(4'd1);
		push_op(OP_INSERT, 32'd1);
		push_op(OP_DELETE, 32'd0);

		// Random phases, each under its own bucket count
		for (phase = 0; phase < 10; phase++) begin
			case (phase)
				0: count = 4'd1;
				1: count = 4'd8;
				2: count = 4'd0;
				3: count = 4'd15;
				4: count = 4'd9;
				default: count = CFG_W'($urandom_range(0, 15));
			endcase
			set_count(count);
			for (n = 0; n < 50; n++) begin
				if (live_keys.size() != 0 && $urandom_range(0, 99) < 45) begin
					if ($urandom_range(0, 4) != 0) begin
						idx = $urandom_range(0, live_keys.size() - 1);
						k = live_keys[idx];
						live_keys.delete(idx);
					end else begin
						k = random_key();
					end
					push_op(OP_DELETE, k);
				end else begin
					k = random_key();
					if (live_keys.size() < 64)
						live_keys.insert(live_keys.size(), k);
					push_op(OP_INSERT, k);
				end
			end
		end

		// Drain, then give any stray result time to show up
		wait_idle();
		repeat (60) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("chained_hash_table_top_tb: PASS");
		else
			$display("chained_hash_table_top_tb: FAIL");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/cht_pkg.sv
rtl/cht_datapath.sv
rtl/cht_ctrl.sv
rtl/chained_hash_table_top.sv
rtl/cht_checker.sv
tb/hash_table_checker.sv
tb/chained_hash_table_top_tb.sv
